// ===== rtl/rbei_pkg.sv =====
package rbei_pkg;

	localparam logic [2:0] REQ_TICK       = 3'd0;
	localparam logic [2:0] REQ_ADD_FORCE  = 3'd1;
	localparam logic [2:0] REQ_IMPULSE    = 3'd2;
	localparam logic [2:0] REQ_ADD_TORQUE = 3'd3;
	localparam logic [2:0] REQ_SET_POS    = 3'd4;
	localparam logic [2:0] REQ_SET_VEL    = 3'd5;

	localparam logic [1:0] REG_INV_MASS      = 2'd0;
	localparam logic [1:0] REG_INV_INERTIA   = 2'd1;
	localparam logic [1:0] REG_TIME_STEP     = 2'd2;
	localparam logic [1:0] REG_INV_TIME_STEP = 2'd3;

	localparam logic [1:0] PH_FIRST  = 2'd0;
	localparam logic [1:0] PH_SECOND = 2'd1;
	localparam logic [1:0] PH_THIRD  = 2'd2;

	typedef struct packed {
		logic       mul;
		logic       wb;
		logic [2:0] op;
		logic [1:0] phase;
	} ctrl_t;

	function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sh0000_0000_7fff_ffff) begin
			r = 32'sh7fff_ffff;
		end else if (v < -64'sh0000_0000_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sadd(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] s;
		logic signed [31:0] r;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31]) begin
			r = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			r = s[31:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/rbei_fmul.sv =====
module rbei_fmul import rbei_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] a,
	input  logic        [30:0] r,
	output logic signed [31:0] res
);

	localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

	logic signed [63:0] prod_q;
	logic signed [63:0] rnd;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * $signed({1'b0, r});
		end
	end

	// round half up, then floor shift and clamp to 32 bits
	assign rnd = (prod_q + HALF) >>> FRAC_BITS;
	assign res = sat64(rnd);

endmodule

// ===== rtl/rbei_axis_lane.sv =====
module rbei_axis_lane import rbei_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ctrl_t              ctrl,
	input  logic signed [31:0] val,
	input  logic        [30:0] inv_mass,
	input  logic        [30:0] time_step,
	input  logic        [30:0] inv_time_step,
	output logic signed [31:0] pos,
	output logic signed [31:0] vel
);

	logic signed [31:0] pos_q, vel_q, force_q, tmp_q;
	logic signed [31:0] mul_a, mul_res;
	logic        [30:0] mul_r;

	always_comb begin
		if (ctrl.op == REQ_IMPULSE) begin
			mul_a = val;
			mul_r = inv_time_step;
		end else begin
			unique case (ctrl.phase)
				PH_FIRST: begin
					mul_a = force_q;
					mul_r = inv_mass;
				end
				PH_SECOND: begin
					mul_a = tmp_q;
					mul_r = time_step;
				end
				default: begin
					mul_a = vel_q;
					mul_r = time_step;
				end
			endcase
		end
	end

	rbei_fmul #(.FRAC_BITS(FRAC_BITS)) u_fmul (
		.clk(clk),
		.en (ctrl.mul),
		.a  (mul_a),
		.r  (mul_r),
		.res(mul_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			vel_q   <= '0;
			force_q <= '0;
			tmp_q   <= '0;
		end else if (ctrl.wb) begin
			unique case (ctrl.op)
				REQ_TICK: begin
					unique case (ctrl.phase)
						PH_FIRST:  tmp_q <= mul_res;
						PH_SECOND: vel_q <= sadd(vel_q, mul_res);
						PH_THIRD: begin
							pos_q   <= sadd(pos_q, mul_res);
							force_q <= '0;
						end
						default: ;
					endcase
				end
				REQ_ADD_FORCE: force_q <= sadd(force_q, val);
				REQ_IMPULSE:   force_q <= mul_res;
				REQ_SET_POS:   pos_q   <= val;
				REQ_SET_VEL:   vel_q   <= val;
				default: ;
			endcase
		end
	end

	assign pos = pos_q;
	assign vel = vel_q;

endmodule

// ===== rtl/rbei_spin_lane.sv =====
module rbei_spin_lane import rbei_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ctrl_t              ctrl,
	input  logic signed [31:0] val,
	input  logic        [30:0] inv_inertia,
	input  logic        [30:0] time_step,
	output logic signed [31:0] angle,
	output logic signed [31:0] ang_vel
);

	logic signed [31:0] rot_q, spin_q, torque_q;
	logic signed [31:0] mul_a, mul_res;
	logic        [30:0] mul_r;

	// angle uses the spin rate from before this tick
	always_comb begin
		if (ctrl.phase == PH_FIRST) begin
			mul_a = spin_q;
			mul_r = time_step;
		end else begin
			mul_a = torque_q;
			mul_r = inv_inertia;
		end
	end

	rbei_fmul #(.FRAC_BITS(FRAC_BITS)) u_fmul (
		.clk(clk),
		.en (ctrl.mul),
		.a  (mul_a),
		.r  (mul_r),
		.res(mul_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q    <= '0;
			spin_q   <= '0;
			torque_q <= '0;
		end else if (ctrl.wb) begin
			unique case (ctrl.op)
				REQ_TICK: begin
					unique case (ctrl.phase)
						PH_FIRST: rot_q <= sadd(rot_q, mul_res);
						PH_SECOND: begin
							spin_q   <= sadd(spin_q, mul_res);
							torque_q <= '0;
						end
						default: ;
					endcase
				end
				REQ_ADD_TORQUE: torque_q <= sadd(torque_q, val);
				default: ;
			endcase
		end
	end

	assign angle   = rot_q;
	assign ang_vel = spin_q;

endmodule

// ===== rtl/rigid_body_euler_integrator.sv =====
// 2d rigid body integrator, semi-implicit euler (explicit for the angle), signed fixed point
//
// s_axis: one request per transfer. tuser carries the request kind
// (tick, add force, impulse, add torque, set position, set velocity),
// tdata carries the x and y values.
// m_axis: one transfer per request with the body state after it.
// cfg: index and data write channel for inv_mass, inv_inertia,
// time_step and inv_time_step; always ready, write only while idle.
//
// the x, y and angular lanes each own one 32x31 multiplier. a tick runs
// three multiply/write-back phases (force*inv_mass, *dt, velocity*dt),
// an impulse one (value*inv_time_step), the other requests a write-back
// only. a new request is taken only once the result has moved from S_PUB
// into the output register.
// a finished result waits in the output register; a new request is
// accepted meanwhile, but its result is held until the register frees.
// reset clears the body state, force and torque and loads the default
// registers (unit inverse mass and inertia, dt of about 1/60, 1/dt of 60).
module rigid_body_euler_integrator import rbei_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata,  // val_x, val_y
	input  logic [2:0]   s_axis_tuser,  // req_type
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [191:0] m_axis_tdata,  // pos_x, pos_y, vel_x, vel_y, angle, ang_vel
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [30:0]  cfg_data
);

	localparam logic [30:0] ONE_RST = 31'(64'd1 << FRAC_BITS);
	localparam logic [30:0] DT_RST  = 31'((64'd1 << FRAC_BITS) / 60);
	localparam logic [30:0] IDT_RST = 31'(64'd60 << FRAC_BITS);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MUL  = 2'd1;
	localparam logic [1:0] S_WB   = 2'd2;
	localparam logic [1:0] S_PUB  = 2'd3;

	logic [1:0]   state_q, phase_q, last_phase;
	logic [2:0]   op_q;
	logic signed [31:0] vx_q, vy_q;
	logic [30:0]  inv_mass_q, inv_inertia_q, time_step_q, inv_time_step_q;
	logic         out_valid_q;
	logic [191:0] out_data_q;
	logic         in_xfer, out_free;
	ctrl_t        ctrl;
	logic signed [31:0] pos_x, pos_y, vel_x, vel_y, angle, ang_vel;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_mass_q      <= ONE_RST;
			inv_inertia_q   <= ONE_RST;
			time_step_q     <= DT_RST;
			inv_time_step_q <= IDT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_INV_MASS:      inv_mass_q      <= cfg_data;
				REG_INV_INERTIA:   inv_inertia_q   <= cfg_data;
				REG_TIME_STEP:     time_step_q     <= cfg_data;
				REG_INV_TIME_STEP: inv_time_step_q <= cfg_data;
			endcase
		end
	end

	assign last_phase = (op_q == REQ_TICK) ? PH_THIRD : PH_FIRST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_FIRST;
			op_q    <= REQ_TICK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						op_q    <= s_axis_tuser;
						phase_q <= PH_FIRST;
						if (s_axis_tuser == REQ_TICK || s_axis_tuser == REQ_IMPULSE) begin
							state_q <= S_MUL;
						end else begin
							state_q <= S_WB;
						end
					end
				end
				S_MUL: state_q <= S_WB;
				S_WB: begin
					if (phase_q == last_phase) begin
						state_q <= S_PUB;
					end else begin
						phase_q <= phase_q + 2'd1;
						state_q <= S_MUL;
					end
				end
				S_PUB: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			vx_q <= s_axis_tdata[31:0];
			vy_q <= s_axis_tdata[63:32];
		end
	end

	assign ctrl.mul   = (state_q == S_MUL);
	assign ctrl.wb    = (state_q == S_WB);
	assign ctrl.op    = op_q;
	assign ctrl.phase = phase_q;

	rbei_axis_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.val          (vx_q),
		.inv_mass     (inv_mass_q),
		.time_step    (time_step_q),
		.inv_time_step(inv_time_step_q),
		.pos          (pos_x),
		.vel          (vel_x)
	);

	rbei_axis_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.val          (vy_q),
		.inv_mass     (inv_mass_q),
		.time_step    (time_step_q),
		.inv_time_step(inv_time_step_q),
		.pos          (pos_y),
		.vel          (vel_y)
	);

	rbei_spin_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_spin (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.val        (vx_q),
		.inv_inertia(inv_inertia_q),
		.time_step  (time_step_q),
		.angle      (angle),
		.ang_vel    (ang_vel)
	);

	// merge the three lanes into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_PUB && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_PUB && out_free) begin
			out_data_q <= {ang_vel, angle, vel_y, vel_x, pos_y, pos_x};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/rbei_checker.sv =====
module rbei_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [191:0] m_axis_tdata,
	input logic         cfg_valid,
	input logic         cfg_ready
);

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed while stalled");

	// one request at a time: busy right after a transfer
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready straight after a transfer");

	// no result can appear in the cycle after a request is taken
	a_no_instant_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
		else $error("result appeared without processing time");

	// configuration port never back-pressures
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind rigid_body_euler_integrator rbei_checker u_rbei_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready)
);
